### src/btl2d_pkg.sv
// Package for the two-dimensional breakpoint table lookup core.
// Holds operation codes, controller states and the command/status structs.
// No dependencies.
package btl2d_pkg;

	localparam int AXIS_DEPTH = 16;
	localparam int AXIS_IW    = 4;
	localparam int VALUE_W    = 16;
	localparam int CELL_W     = 8;
	localparam int OFFSET_W   = 8;
	localparam int OP_W       = 3;

	typedef enum logic [OP_W-1:0] {
		OP_LOOKUP              = 3'd0,
		OP_CELL_WRITE          = 3'd1,
		OP_CELL_READ           = 3'd2,
		OP_PRESSURE_AXIS_WRITE = 3'd3,
		OP_SPEED_AXIS_WRITE    = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_P,
		ST_SCAN_S,
		ST_READ,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic scan_clr;
		logic scan_p;
		logic scan_s;
		logic mem_rd;
		logic mem_wr;
		logic axis_wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic p_done;
		logic s_done;
		logic out_free;
	} status_t;

endpackage

### src/btl2d_ctrl.sv
// Controller state machine for the breakpoint table lookup core.
// Sequences decode, cell and axis writes, axis scans, cell read and result load; uses btl2d_pkg.
module btl2d_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  btl2d_pkg::status_t status,
	output btl2d_pkg::cmd_t    cmd
);
	import btl2d_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (status.op)
					OP_LOOKUP: begin
						cmd.scan_clr = 1'b1;
						state_d      = ST_SCAN_P;
					end
					OP_CELL_WRITE: begin
						cmd.mem_wr = 1'b1;
						state_d    = ST_DONE;
					end
					OP_CELL_READ: begin
						state_d = ST_READ;
					end
					OP_PRESSURE_AXIS_WRITE, OP_SPEED_AXIS_WRITE: begin
						cmd.axis_wr = 1'b1;
						state_d     = ST_DONE;
					end
					default: begin
						state_d = ST_DONE;
					end
				endcase
			end
			ST_SCAN_P: begin
				cmd.scan_p = 1'b1;
				if (status.p_done) begin
					state_d = ST_SCAN_S;
				end
			end
			ST_SCAN_S: begin
				cmd.scan_s = 1'b1;
				if (status.s_done) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_load_decodes: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_DECODE)
		else $error("accepted item did not move to decode");

	a_done_releases: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && status.out_free) |=> state_q == ST_IDLE)
		else $error("result load did not return to idle");

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> state_q == ST_IDLE)
		else $error("input ready outside idle");

endmodule

### src/btl2d_dpath.sv
// Datapath for the breakpoint table lookup core: item registers, axes,
// serial breakpoint scan, cell memory and output register; uses btl2d_pkg.
module btl2d_dpath #(
	parameter int PRESSURE_BINS = 16,
	parameter int SPEED_BINS    = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [2:0]         in_op,
	input  logic [15:0]        in_pressure,
	input  logic [15:0]        in_speed,
	input  logic [7:0]         in_offset,
	input  logic [3:0]         in_axis_index,
	input  logic [15:0]        in_new_value,
	input  btl2d_pkg::cmd_t    cmd,
	output btl2d_pkg::status_t status,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_cell,
	output logic [3:0]         out_pbin,
	output logic [3:0]         out_sbin,
	output logic               out_err
);
	import btl2d_pkg::*;

	localparam int CELL_COUNT = PRESSURE_BINS * SPEED_BINS;
	localparam int CAW        = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

	op_t                 op_q;
	logic [VALUE_W-1:0]  pv_q;
	logic [VALUE_W-1:0]  sv_q;
	logic [OFFSET_W-1:0] off_q;
	logic [AXIS_IW-1:0]  idx_q;
	logic [VALUE_W-1:0]  nv_q;

	logic [VALUE_W-1:0]  paxis_q [AXIS_DEPTH];
	logic [VALUE_W-1:0]  saxis_q [AXIS_DEPTH];
	logic [AXIS_IW-1:0]  scan_q;
	logic [AXIS_IW-1:0]  pbin_q;
	logic [AXIS_IW-1:0]  sbin_q;

	logic [CELL_W-1:0]   cell_mem [CELL_COUNT];
	logic [CELL_COUNT-1:0] cell_vld_q;
	logic [CELL_W-1:0]   rd_data_q;
	logic                rd_vld_q;

	logic                out_valid_q;
	logic [CELL_W-1:0]   out_cell_q;
	logic [AXIS_IW-1:0]  out_pbin_q;
	logic [AXIS_IW-1:0]  out_sbin_q;
	logic                out_err_q;

	logic                p_hit;
	logic                s_hit;
	logic                p_last;
	logic                s_last;
	logic [AXIS_IW-1:0]  scan_bin;
	logic                off_ok;
	logic [OFFSET_W-1:0] flat;
	logic [CAW-1:0]      rd_addr;
	logic [CAW-1:0]      wr_addr;
	logic                cell_ok;

	assign p_hit    = pv_q < paxis_q[scan_q];
	assign s_hit    = sv_q < saxis_q[scan_q];
	assign p_last   = scan_q == AXIS_IW'(PRESSURE_BINS - 1);
	assign s_last   = scan_q == AXIS_IW'(SPEED_BINS - 1);
	assign scan_bin = (scan_q == '0) ? '0 : scan_q - AXIS_IW'(1);
	assign off_ok   = {1'b0, off_q} < (OFFSET_W + 1)'(CELL_COUNT);
	assign flat     = {{(OFFSET_W - AXIS_IW){1'b0}}, pbin_q} * OFFSET_W'(SPEED_BINS)
		+ {{(OFFSET_W - AXIS_IW){1'b0}}, sbin_q};
	assign wr_addr  = off_q[CAW-1:0];
	assign rd_addr  = (op_q == OP_LOOKUP) ? flat[CAW-1:0] : off_q[CAW-1:0];
	assign cell_ok  = (op_q == OP_LOOKUP) || (op_q == OP_CELL_READ && off_ok);

	assign status.op       = op_q;
	assign status.p_done   = p_hit || p_last;
	assign status.s_done   = s_hit || s_last;
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= op_t'(in_op);
			pv_q  <= in_pressure;
			sv_q  <= in_speed;
			off_q <= in_offset;
			idx_q <= in_axis_index;
			nv_q  <= in_new_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AXIS_DEPTH; i++) begin
				paxis_q[i] <= '0;
				saxis_q[i] <= '0;
			end
		end else if (cmd.axis_wr) begin
			if (op_q == OP_PRESSURE_AXIS_WRITE
				&& {1'b0, idx_q} < (AXIS_IW + 1)'(PRESSURE_BINS)) begin
				paxis_q[idx_q] <= nv_q;
			end
			if (op_q == OP_SPEED_AXIS_WRITE
				&& {1'b0, idx_q} < (AXIS_IW + 1)'(SPEED_BINS)) begin
				saxis_q[idx_q] <= nv_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			pbin_q <= '0;
			sbin_q <= '0;
		end else if (cmd.scan_clr) begin
			scan_q <= '0;
		end else if (cmd.scan_p) begin
			if (p_hit || p_last) begin
				pbin_q <= p_hit ? scan_bin : scan_q;
				scan_q <= '0;
			end else begin
				scan_q <= scan_q + AXIS_IW'(1);
			end
		end else if (cmd.scan_s) begin
			if (s_hit || s_last) begin
				sbin_q <= s_hit ? scan_bin : scan_q;
				scan_q <= '0;
			end else begin
				scan_q <= scan_q + AXIS_IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mem_wr && off_ok) begin
			cell_mem[wr_addr] <= nv_q[CELL_W-1:0];
		end
		if (cmd.mem_rd) begin
			rd_data_q <= cell_mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_vld_q <= '0;
			rd_vld_q   <= 1'b0;
		end else begin
			if (cmd.mem_wr && off_ok) begin
				cell_vld_q[wr_addr] <= 1'b1;
			end
			if (cmd.mem_rd) begin
				rd_vld_q <= cell_vld_q[rd_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_cell_q <= (cell_ok && rd_vld_q) ? rd_data_q : '0;
			out_pbin_q <= (op_q == OP_LOOKUP) ? pbin_q : '0;
			out_sbin_q <= (op_q == OP_LOOKUP) ? sbin_q : '0;
			out_err_q  <= (op_q == OP_CELL_WRITE || op_q == OP_CELL_READ) && !off_ok;
		end
	end

	assign out_valid = out_valid_q;
	assign out_cell  = out_cell_q;
	assign out_pbin  = out_pbin_q;
	assign out_sbin  = out_sbin_q;
	assign out_err   = out_err_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while held");

	a_scan_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.scan_p && cmd.scan_s))
		else $error("both axis scans active");

	a_bins_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, pbin_q} < (AXIS_IW + 1)'(PRESSURE_BINS))
		&& ({1'b0, sbin_q} < (AXIS_IW + 1)'(SPEED_BINS)))
		else $error("bin beyond axis length");

endmodule

### src/breakpoint_table_lookup_2d_core.sv
// Top level of the two-dimensional breakpoint table lookup core.
// Joins btl2d_ctrl and btl2d_dpath; uses btl2d_pkg.
//
// channel  | dir | tdata                                   | tuser
// s_axis   | in  | pressure, speed, offset, index, new val | operation
// m_axis   | out | cell, pressure bin, speed bin           | offset error
//
// One item at a time. A lookup scans one breakpoint per cycle on each axis:
// it passes decode, the pressure scan, the speed scan, the cell read and the
// result load; a cell read skips the scans, and the writes skip the read too.
// Reset clears axes and cell valid bits at once; no clearing pass.
// A result held in the output register stalls the next one in its last step.
module breakpoint_table_lookup_2d_core #(
	parameter int PRESSURE_BINS = 16,
	parameter int SPEED_BINS    = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [15:0] pressure_value, [31:16] speed_value, [39:32] cell_offset,
	// [43:40] axis_index, [59:44] new_value, [63:60] zero
	input  logic [63:0] s_axis_tdata,
	// [2:0] operation
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] cell_value, [11:8] pressure_bin, [15:12] speed_bin
	output logic [15:0] m_axis_tdata,
	// [0] offset_error
	output logic [0:0]  m_axis_tuser
);
	import btl2d_pkg::*;

	cmd_t       cmd;
	status_t    status;
	logic [7:0] out_cell;
	logic [3:0] out_pbin;
	logic [3:0] out_sbin;
	logic       out_err;

	btl2d_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	btl2d_dpath #(
		.PRESSURE_BINS (PRESSURE_BINS),
		.SPEED_BINS    (SPEED_BINS)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_op         (s_axis_tuser),
		.in_pressure   (s_axis_tdata[15:0]),
		.in_speed      (s_axis_tdata[31:16]),
		.in_offset     (s_axis_tdata[39:32]),
		.in_axis_index (s_axis_tdata[43:40]),
		.in_new_value  (s_axis_tdata[59:44]),
		.cmd           (cmd),
		.status        (status),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_cell      (out_cell),
		.out_pbin      (out_pbin),
		.out_sbin      (out_sbin),
		.out_err       (out_err)
	);

	assign m_axis_tdata = {out_sbin, out_pbin, out_cell};
	assign m_axis_tuser = out_err;

endmodule
